@@ hw/rtl/dcmsl_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package dcmsl_pkg;

    // Field widths
    localparam int KNOB_W  = 12;
    localparam int COUNT_W = 32;
    localparam int DUTY_W  = 12;
    localparam int RPM_W   = 16;
    localparam int ERR_W   = 17;
    localparam int GAIN_W  = 8;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 104;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // Register indexes (byte address / 4)
    localparam logic [1:0] REG_MAX_RPM  = 2'd0;
    localparam logic [1:0] REG_GAIN     = 2'd1;
    localparam logic [1:0] REG_DECEL    = 2'd2;
    localparam logic [1:0] REG_DEADZONE = 2'd3;

    // Register reset values
    localparam logic [11:0] MAX_RPM_RST  = 12'd150;
    localparam logic [7:0]  GAIN_RST     = 8'd5;
    localparam logic [11:0] DECEL_RST    = 12'd600;
    localparam logic [11:0] DEADZONE_RST = 12'd100;

    localparam logic [DUTY_W-1:0] DUTY_MAX = 12'd4095;

    // Knob full scale; the quotient correction subtracts this
    localparam logic [12:0] KNOB_FULL = 13'd4095;

    // rpm = delta*120/410 = (delta*12)/41, done as (delta*12)*RPM_RECIP >> RPM_SHIFT.
    // Exact for delta*12 below 2^28/31, which covers every unsaturated delta.
    localparam logic [23:0] RPM_RECIP = 24'd6547207;
    localparam int          RPM_SHIFT = 28;
    // Smallest delta whose rpm exceeds 65535
    localparam logic [COUNT_W-1:0] DELTA_SAT = 32'd223915;

    // Run mode state, one-hot; the result carries the 2-bit mode code
    typedef enum logic [2:0] {
        MODE_READY = 3'b001,
        MODE_DECEL = 3'b010,
        MODE_WAIT  = 3'b100
    } t_mode;

    localparam logic [1:0] MODE_CODE_READY = 2'd0;
    localparam logic [1:0] MODE_CODE_DECEL = 2'd1;
    localparam logic [1:0] MODE_CODE_WAIT  = 2'd2;

    // Map the run mode to its result code
    function automatic logic [1:0] mode_code(input t_mode m);
        logic [1:0] c;
        c = MODE_CODE_READY;
        unique case (m)
            MODE_READY: c = MODE_CODE_READY;
            MODE_DECEL: c = MODE_CODE_DECEL;
            MODE_WAIT:  c = MODE_CODE_WAIT;
            default:    c = MODE_CODE_READY;
        endcase
        return c;
    endfunction

    // Multiplier operand selection
    typedef enum logic [1:0] {
        MS_NONE   = 2'd0,
        MS_TARGET = 2'd1,
        MS_RPM    = 2'd2,
        MS_GAIN   = 2'd3
    } t_mul_sel;

    // Datapath operation
    typedef enum logic [2:0] {
        OP_DELTA  = 3'd0,
        OP_SPLIT  = 3'd1,
        OP_FIX    = 3'd2,
        OP_TARGET = 3'd3,
        OP_RPM    = 3'd4,
        OP_ERR    = 3'd5,
        OP_NOP    = 3'd6,
        OP_UPDATE = 3'd7
    } t_alu_op;

    // Sequencing
    typedef enum logic [1:0] {
        J_NEXT   = 2'd0,
        J_REM_GE = 2'd1,
        J_DONE   = 2'd2
    } t_jmp;

    typedef logic [2:0] t_step;

    typedef struct packed {
        t_mul_sel mul_sel;
        t_alu_op  alu_op;
        t_jmp     jmp;
        t_step    jmp_to;
    } t_uop;

    // Program step numbers
    localparam t_step ST_TMUL   = 3'd0;
    localparam t_step ST_SPLIT  = 3'd1;
    localparam t_step ST_FIX    = 3'd2;
    localparam t_step ST_RMUL   = 3'd3;
    localparam t_step ST_RPM    = 3'd4;
    localparam t_step ST_ERR    = 3'd5;
    localparam t_step ST_EMUL   = 3'd6;
    localparam t_step ST_UPDATE = 3'd7;

    // Control store: one word per step
    function automatic t_uop uop_rom(input t_step step);
        t_uop u;
        u = '{mul_sel: MS_NONE, alu_op: OP_NOP, jmp: J_NEXT, jmp_to: ST_TMUL};
        unique case (step)
            ST_TMUL:   u = '{mul_sel: MS_TARGET, alu_op: OP_DELTA,  jmp: J_NEXT,
                             jmp_to: ST_TMUL};
            ST_SPLIT:  u = '{mul_sel: MS_NONE,   alu_op: OP_SPLIT,  jmp: J_NEXT,
                             jmp_to: ST_TMUL};
            ST_FIX:    u = '{mul_sel: MS_NONE,   alu_op: OP_FIX,    jmp: J_REM_GE,
                             jmp_to: ST_FIX};
            ST_RMUL:   u = '{mul_sel: MS_RPM,    alu_op: OP_TARGET, jmp: J_NEXT,
                             jmp_to: ST_TMUL};
            ST_RPM:    u = '{mul_sel: MS_NONE,   alu_op: OP_RPM,    jmp: J_NEXT,
                             jmp_to: ST_TMUL};
            ST_ERR:    u = '{mul_sel: MS_NONE,   alu_op: OP_ERR,    jmp: J_NEXT,
                             jmp_to: ST_TMUL};
            ST_EMUL:   u = '{mul_sel: MS_GAIN,   alu_op: OP_NOP,    jmp: J_NEXT,
                             jmp_to: ST_TMUL};
            ST_UPDATE: u = '{mul_sel: MS_NONE,   alu_op: OP_UPDATE, jmp: J_DONE,
                             jmp_to: ST_TMUL};
            default:   u = '{mul_sel: MS_NONE,   alu_op: OP_NOP,    jmp: J_NEXT,
                             jmp_to: ST_TMUL};
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/dc_motor_speed_loop_with_reversal_top.sv @@
// Speed loop for a DC motor with a safe reversal ramp. Each input item is one
// control tick carrying a knob sample, the requested direction and the
// free-running encoder count; each tick yields exactly one result item with
// both half-bridge duties, target and measured rpm, the speed error, the run
// mode, the driven direction and the pulses seen since the previous tick.
// One tick is processed at a time by an eight-step microprogram sharing one
// 25x25 multiplier: the quotient correction for the knob scaling repeats its
// step while the remainder is at least full scale, and the last step holds
// while the previous result still waits on the output. The block is ready for
// the next tick in the cycle after the result is loaded, even while
// that result still waits on the output. The four registers (full-scale rpm,
// loop gain, reversal ramp step, knob dead zone) sit at byte addresses
// 0x0, 0x4, 0x8 and 0xC and should be written only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module dc_motor_speed_loop_with_reversal_top
    import dcmsl_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // tick input
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // [11:0] knob_sample, [12] direction_request, [44:13] pulse_count, [47:45] zero
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // result output
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [11:0] forward_duty, [23:12] reverse_duty, [35:24] target_speed,
    // [51:36] measured_speed, [68:52] speed_error, [70:69] mode_out,
    // [71] direction_out, [103:72] tick_pulses
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    // configuration
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready
);

    // Configuration registers
    logic [11:0]       r_max_rpm;
    logic [GAIN_W-1:0] r_gain;
    logic [11:0]       r_decel;
    logic [11:0]       r_deadzone;

    // Sequencer
    logic  r_busy;
    t_step r_step;
    t_step n_step;
    t_uop  uop;

    // Captured tick
    logic [KNOB_W-1:0]  r_knob;
    logic               r_req;
    logic [COUNT_W-1:0] r_count;

    // Datapath
    logic signed [49:0] r_prod;
    logic signed [49:0] n_prod;
    logic signed [24:0] mul_a;
    logic signed [24:0] mul_b;
    logic [COUNT_W-1:0] r_delta;
    logic [21:0]        r_x41;
    logic [11:0]        r_quot;
    logic [12:0]        r_rem;
    logic [KNOB_W-1:0]  r_target;
    logic [RPM_W-1:0]   r_rpm;
    logic signed [ERR_W-1:0] r_err;

    // Control state
    logic [DUTY_W-1:0]  r_level;
    t_mode              r_mode;
    logic               r_dir;
    logic [COUNT_W-1:0] r_prev;
    logic               r_started;

    logic [DUTY_W-1:0]  n_level;
    t_mode              n_mode;
    logic               n_dir;

    // Output register
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic in_acc;
    logic out_free;
    logic rem_ge;
    logic finish;

    logic signed [26:0] upd_sum;
    logic               dir_eff;
    t_mode              mode_a;

    assign pready        = 1'b1;
    assign s_axis_tready = ~r_busy;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    assign in_acc   = s_axis_tvalid & ~r_busy;
    assign out_free = ~r_out_valid | m_axis_tready;
    assign uop      = uop_rom(r_step);
    assign rem_ge   = (r_rem >= KNOB_FULL);
    assign finish   = r_busy & (uop.jmp == J_DONE) & out_free;

    // Register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_rpm  <= MAX_RPM_RST;
            r_gain     <= GAIN_RST;
            r_decel    <= DECEL_RST;
            r_deadzone <= DEADZONE_RST;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                REG_MAX_RPM:  r_max_rpm  <= pwdata[11:0];
                REG_GAIN:     r_gain     <= pwdata[GAIN_W-1:0];
                REG_DECEL:    r_decel    <= pwdata[11:0];
                REG_DEADZONE: r_deadzone <= pwdata[11:0];
                default:      r_max_rpm  <= r_max_rpm;
            endcase
        end
    end

    // Register read
    always_comb begin
        unique case (paddr[3:2])
            REG_MAX_RPM:  prdata = {20'd0, r_max_rpm};
            REG_GAIN:     prdata = {24'd0, r_gain};
            REG_DECEL:    prdata = {20'd0, r_decel};
            REG_DEADZONE: prdata = {20'd0, r_deadzone};
            default:      prdata = '0;
        endcase
    end

    // Next step: advance, loop on the quotient fix, hold at the end for the output slot
    always_comb begin
        n_step = r_step;
        unique case (uop.jmp)
            J_NEXT:   n_step = r_step + 3'd1;
            J_REM_GE: n_step = rem_ge ? uop.jmp_to : r_step + 3'd1;
            J_DONE:   n_step = out_free ? ST_TMUL : r_step;
            default:  n_step = r_step;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= ST_TMUL;
        end else if (!r_busy) begin
            if (in_acc) begin
                r_busy <= 1'b1;
                r_step <= ST_TMUL;
            end
        end else begin
            r_step <= n_step;
            if (finish) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Capture the tick
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_knob  <= s_axis_tdata[11:0];
            r_req   <= s_axis_tdata[12];
            r_count <= s_axis_tdata[44:13];
        end
    end

    // Shared multiplier operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (uop.mul_sel)
            MS_TARGET: begin
                mul_a = {13'd0, r_knob};
                mul_b = {13'd0, r_max_rpm};
            end
            MS_RPM: begin
                mul_a = {3'd0, r_x41};
                mul_b = {1'b0, RPM_RECIP};
            end
            MS_GAIN: begin
                mul_a = {{(25-ERR_W){r_err[ERR_W-1]}}, r_err};
                mul_b = {17'd0, r_gain};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign n_prod = mul_a * mul_b;

    always_ff @(posedge i_clk) begin
        if (r_busy && uop.mul_sel != MS_NONE) begin
            r_prod <= n_prod;
        end
    end

    // Control update for the last step
    assign upd_sum = $signed({15'd0, r_level}) + $signed(r_prod[26:0]);
    assign dir_eff = r_started ? r_dir : r_req;
    assign mode_a  = (r_mode == MODE_READY) ? MODE_DECEL : r_mode;

    always_comb begin
        n_level = r_level;
        n_mode  = r_mode;
        n_dir   = dir_eff;
        if (r_req != dir_eff) begin
            if (mode_a == MODE_DECEL) begin
                if (r_level > r_decel) begin
                    n_level = r_level - r_decel;
                    n_mode  = MODE_DECEL;
                end else begin
                    n_level = '0;
                    n_mode  = MODE_WAIT;
                end
            end else begin
                n_level = '0;
                n_mode  = mode_a;
                if (r_delta == '0) begin
                    n_dir  = r_req;
                    n_mode = MODE_READY;
                end
            end
        end else begin
            n_mode = MODE_READY;
            if (r_target == '0) begin
                n_level = '0;
            end else if (upd_sum < 0) begin
                n_level = '0;
            end else if (upd_sum > $signed({15'd0, DUTY_MAX})) begin
                n_level = DUTY_MAX;
            end else begin
                n_level = upd_sum[DUTY_W-1:0];
            end
        end
    end

    // Datapath operations
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            unique case (uop.alu_op)
                OP_DELTA: begin
                    r_delta <= r_count - r_prev;
                end
                OP_SPLIT: begin
                    // x/4096 undershoots x/4095 by at most one
                    r_quot <= r_prod[23:12];
                    r_rem  <= {1'b0, r_prod[11:0]} + {1'b0, r_prod[23:12]};
                    r_x41  <= {r_delta[17:0], 3'd0} + {1'b0, r_delta[17:0], 2'd0};
                end
                OP_FIX: begin
                    if (rem_ge) begin
                        r_rem  <= r_rem - KNOB_FULL;
                        r_quot <= r_quot + 12'd1;
                    end
                end
                OP_TARGET: begin
                    r_target <= (r_knob >= r_deadzone) ? r_quot : '0;
                end
                OP_RPM: begin
                    r_rpm <= (r_delta >= DELTA_SAT) ? '1
                           : r_prod[RPM_SHIFT+RPM_W-1:RPM_SHIFT];
                end
                OP_ERR: begin
                    r_err <= $signed({5'd0, r_target}) - $signed({1'b0, r_rpm});
                end
                OP_NOP: begin
                    r_rem <= r_rem;
                end
                OP_UPDATE: begin
                    r_rem <= r_rem;
                end
                default: begin
                    r_rem <= r_rem;
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level   <= '0;
            r_mode    <= MODE_READY;
            r_dir     <= 1'b1;
            r_prev    <= '0;
            r_started <= 1'b0;
        end else if (r_busy) begin
            if (uop.alu_op == OP_DELTA) begin
                r_prev <= r_count;
            end
            if (finish) begin
                r_level   <= n_level;
                r_mode    <= n_mode;
                r_dir     <= n_dir;
                r_started <= 1'b1;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_out_data <= {r_delta, n_dir, mode_code(n_mode), r_err, r_rpm, r_target,
                           n_dir ? {DUTY_W{1'b0}} : n_level,
                           n_dir ? n_level : {DUTY_W{1'b0}}};
        end
    end

endmodule

`default_nettype wire

@@ tb/sv/dc_motor_speed_loop_with_reversal_checker.sv @@
`timescale 1ns / 1ps

// Watch the tick and result channels and the register port. Predict each
// result from the accepted ticks and compare it field by field.
module dc_motor_speed_loop_with_reversal_checker
    import dcmsl_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_tick_valid,
    input  logic                  i_tick_ready,
    // [11:0] knob_sample, [12] direction_request, [44:13] pulse_count
    input  logic [IN_DATA_W-1:0]  i_tick_data,
    input  logic                  i_res_valid,
    input  logic                  i_res_ready,
    // [11:0] forward_duty, [23:12] reverse_duty, [35:24] target_speed,
    // [51:36] measured_speed, [68:52] speed_error, [70:69] mode_out,
    // [71] direction_out, [103:72] tick_pulses
    input  logic [OUT_DATA_W-1:0] i_res_data,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic [APB_ADDR_W-1:0] i_paddr,
    input  logic [APB_DATA_W-1:0] i_pwdata,
    input  logic [APB_DATA_W-1:0] i_prdata,
    input  logic                  i_pready,
    output int                    o_errors,
    output int                    o_pending
);

    localparam int FULL_SCALE   = 4095;
    localparam int RPM_NUM      = 120;
    localparam int PULSES_REV   = 410;
    localparam int RPM_CEIL     = 65535;

    typedef struct packed {
        logic [DUTY_W-1:0]  fwd_duty;
        logic [DUTY_W-1:0]  rev_duty;
        logic [11:0]        target;
        logic [RPM_W-1:0]   rpm;
        logic [ERR_W-1:0]   err;
        logic [1:0]         mode;
        logic               dir;
        logic [COUNT_W-1:0] pulses;
    } t_tick_result;

    // register copies
    logic [11:0]        cfg_max_rpm;
    logic [GAIN_W-1:0]  cfg_gain;
    logic [11:0]        cfg_decel;
    logic [11:0]        cfg_deadzone;

    // controller state
    longint             drive_lvl;
    t_mode              run_state;
    logic               drive_dir;
    logic [COUNT_W-1:0] last_count;
    logic               seen_tick;

    t_tick_result       due_results[$];
    int                 mismatches;
    int                 results_seen;

    task automatic note_mismatch(input string what);
        mismatches++;
        $display("%0t checker: %s", $time, what);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            note_mismatch($sformatf("result %0d %s got %0h want %0h",
                                    results_seen, name, got, want));
    endtask

    // Advance the controller by one tick and return the result it yields.
    function automatic t_tick_result control_tick(input logic [11:0] knob,
                                                  input logic req,
                                                  input logic [COUNT_W-1:0] count);
        t_tick_result r;
        logic [11:0]        target;
        logic [COUNT_W-1:0] delta;
        longint             delta_l;
        longint             rpm;
        longint             err;
        longint             target_l;
        target = '0;
        if (knob >= cfg_deadzone)
            target = 12'((int'(knob) * int'(cfg_max_rpm)) / FULL_SCALE);
        delta = count - last_count;
        last_count = count;
        delta_l = delta;
        rpm = (delta_l * RPM_NUM) / PULSES_REV;
        if (rpm > RPM_CEIL)
            rpm = RPM_CEIL;
        target_l = target;
        err = target_l - rpm;

        // first tick takes the requested direction
        if (!seen_tick) begin
            drive_dir = req;
            seen_tick = 1'b1;
        end

        if (req != drive_dir) begin
            if (run_state == MODE_READY)
                run_state = MODE_DECEL;
            if (run_state == MODE_DECEL) begin
                if (drive_lvl > longint'(cfg_decel)) begin
                    drive_lvl = drive_lvl - longint'(cfg_decel);
                end else begin
                    drive_lvl = 0;
                    run_state = MODE_WAIT;
                end
            end else begin
                // hold zero until the motor has stopped
                drive_lvl = 0;
                if (delta == '0) begin
                    drive_dir = req;
                    run_state = MODE_READY;
                end
            end
        end else begin
            run_state = MODE_READY;
            if (target == '0)
                drive_lvl = 0;
            else
                drive_lvl = drive_lvl + err * longint'(cfg_gain);
        end

        if (drive_lvl < 0)
            drive_lvl = 0;
        if (drive_lvl > longint'(DUTY_MAX))
            drive_lvl = longint'(DUTY_MAX);

        r.fwd_duty = drive_dir ? DUTY_W'(drive_lvl) : '0;
        r.rev_duty = drive_dir ? '0 : DUTY_W'(drive_lvl);
        r.target   = target;
        r.rpm      = RPM_W'(rpm);
        r.err      = ERR_W'(err);
        r.mode     = mode_code(run_state);
        r.dir      = drive_dir;
        r.pulses   = delta;
        return r;
    endfunction

    function automatic logic [APB_DATA_W-1:0] reg_value(input logic [1:0] idx);
        logic [APB_DATA_W-1:0] v;
        v = '0;
        case (idx)
            REG_MAX_RPM:  v = APB_DATA_W'(cfg_max_rpm);
            REG_GAIN:     v = APB_DATA_W'(cfg_gain);
            REG_DECEL:    v = APB_DATA_W'(cfg_decel);
            REG_DEADZONE: v = APB_DATA_W'(cfg_deadzone);
            default:      v = '0;
        endcase
        return v;
    endfunction

    always @(posedge i_clk) begin : watch
        t_tick_result want;
        t_tick_result got;
        logic [1:0]   idx;
        idx = i_paddr[3:2];
        if (!i_rst_n) begin
            cfg_max_rpm  = MAX_RPM_RST;
            cfg_gain     = GAIN_RST;
            cfg_decel    = DECEL_RST;
            cfg_deadzone = DEADZONE_RST;
            drive_lvl    = 0;
            run_state    = MODE_READY;
            drive_dir    = 1'b1;
            last_count   = '0;
            seen_tick    = 1'b0;
            due_results.delete();
        end else begin
            // follow register writes, check reads
            if (i_psel && i_penable && i_pready) begin
                if (i_pwrite) begin
                    case (idx)
                        REG_MAX_RPM:  cfg_max_rpm  = i_pwdata[11:0];
                        REG_GAIN:     cfg_gain     = i_pwdata[GAIN_W-1:0];
                        REG_DECEL:    cfg_decel    = i_pwdata[11:0];
                        REG_DEADZONE: cfg_deadzone = i_pwdata[11:0];
                        default: ;
                    endcase
                end else if (i_prdata !== reg_value(idx)) begin
                    note_mismatch($sformatf("register %0d read %0h want %0h",
                                            idx, i_prdata, reg_value(idx)));
                end
            end

            // predict from each accepted tick
            if (i_tick_valid && i_tick_ready)
                due_results.push_back(control_tick(i_tick_data[11:0], i_tick_data[12],
                                                   i_tick_data[44:13]));

            // compare each accepted result with the oldest prediction
            if (i_res_valid && i_res_ready) begin
                got.fwd_duty = i_res_data[11:0];
                got.rev_duty = i_res_data[23:12];
                got.target   = i_res_data[35:24];
                got.rpm      = i_res_data[51:36];
                got.err      = i_res_data[68:52];
                got.mode     = i_res_data[70:69];
                got.dir      = i_res_data[71];
                got.pulses   = i_res_data[103:72];
                if (due_results.size() == 0) begin
                    note_mismatch($sformatf("result %0d with no tick pending",
                                            results_seen));
                end else begin
                    want = due_results.pop_front();
                    check_field("forward_duty", 32'(got.fwd_duty), 32'(want.fwd_duty));
                    check_field("reverse_duty", 32'(got.rev_duty), 32'(want.rev_duty));
                    check_field("target_speed", 32'(got.target), 32'(want.target));
                    check_field("measured_speed", 32'(got.rpm), 32'(want.rpm));
                    check_field("speed_error", 32'(got.err), 32'(want.err));
                    check_field("mode_out", 32'(got.mode), 32'(want.mode));
                    check_field("direction_out", 32'(got.dir), 32'(want.dir));
                    check_field("tick_pulses", got.pulses, want.pulses);
                end
                results_seen++;
            end
        end
        o_pending <= due_results.size();
        o_errors  <= mismatches;
    end

endmodule

@@ tb/sv/dc_motor_speed_loop_with_reversal_top_tb.sv @@
`timescale 1ns / 1ps

module dc_motor_speed_loop_with_reversal_top_tb;
    import dcmsl_pkg::*;

    localparam int QUIET_LIMIT  = 4000;
    localparam int TAIL_CYCLES  = 40;
    localparam int PHASES       = 9;
    localparam int PHASE_TICKS  = 72;
    localparam int DIRECTED_N   = 24;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int errors;
    int pending;
    int idle_pct = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;
    int ticks_sent = 0;
    int settings_used = 0;
    logic [11:0] cur_deadzone = DEADZONE_RST;

    dc_motor_speed_loop_with_reversal_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    dc_motor_speed_loop_with_reversal_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tick_valid (s_axis_tvalid),
        .i_tick_ready (s_axis_tready),
        .i_tick_data  (s_axis_tdata),
        .i_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .i_res_data   (m_axis_tdata),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .i_pready     (pready),
        .o_errors     (errors),
        .o_pending    (pending)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // stall the result side at random
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("dc_motor_speed_loop_with_reversal_top_tb: done, errors");
                $finish;
            end
        end
    end

    // one register transfer: setup, access until pready, then idle
    task automatic reg_access(input logic wr, input logic [1:0] idx,
                              input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // write all four registers, junk in the unused upper bits, then read back
    task automatic load_settings(input logic [11:0] max_rpm, input logic [7:0] gain,
                                 input logic [11:0] decel, input logic [11:0] deadzone);
        reg_access(1'b1, REG_MAX_RPM, {20'($urandom_range(1048575)), max_rpm});
        reg_access(1'b1, REG_GAIN, {24'($urandom_range(16777215)), gain});
        reg_access(1'b1, REG_DECEL, {20'($urandom_range(1048575)), decel});
        reg_access(1'b1, REG_DEADZONE, {20'($urandom_range(1048575)), deadzone});
        reg_access(1'b0, REG_MAX_RPM, '0);
        reg_access(1'b0, REG_GAIN, '0);
        reg_access(1'b0, REG_DECEL, '0);
        reg_access(1'b0, REG_DEADZONE, '0);
        cur_deadzone = deadzone;
        settings_used++;
    endtask

    // present one tick, idling first at random; valid stays up afterwards
    task automatic send_tick(input logic [11:0] knob, input logic dir,
                             input logic [COUNT_W-1:0] count);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, count, dir, knob};
        do @(posedge i_clk); while (!s_axis_tready);
        ticks_sent++;
    endtask

    // drop valid and wait until every predicted result has come out
    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int unsigned dir_knob[DIRECTED_N];
        bit          dir_req[DIRECTED_N];
        int unsigned dir_count[DIRECTED_N];
        logic [COUNT_W-1:0] enc_count;
        logic [11:0] knob;
        logic        want_dir;
        logic        dir;
        int          k;

        // First tick takes reverse, climb into the clamp, ramp down, restore
        // the direction mid-ramp, ramp to the stop wait, adopt on zero pulses,
        // then knob and pulse-count extremes.
        dir_knob  = '{4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095, 2048, 2048,
                      2048, 2048, 2048, 2048, 2048, 2048, 99, 100, 0, 4095,
                      4095, 4095, 4095, 2730};
        dir_req   = '{0, 0, 0, 0, 0, 0, 1, 1, 0, 1,
                      1, 1, 1, 1, 1, 1, 1, 1, 1, 1,
                      1, 1, 0, 0};
        dir_count = '{0, 0, 0, 0, 0, 0, 100, 300, 400, 500,
                      510, 520, 530, 540, 540, 540, 541, 542, 32'hFFFF_FFFF, 0,
                      223914, 447829, 447829, 32'h8000_0000};

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed ticks under the reset register values
        for (int i = 0; i < DIRECTED_N; i++)
            send_tick(12'(dir_knob[i]), dir_req[i], COUNT_W'(dir_count[i]));
        hold_until_drained();

        enc_count = COUNT_W'(dir_count[DIRECTED_N-1]);
        want_dir  = 1'b0;
        for (int ph = 0; ph < PHASES; ph++) begin
            idle_pct  = 0;
            stall_pct = 0;
            case (ph)
                0: load_settings(12'd4095, 8'd255, 12'd4095, 12'd0);
                1: load_settings(12'd0, 8'd0, 12'd0, 12'd4095);
                2: load_settings(12'd150, 8'd5, 12'd0, 12'd100);
                3: load_settings(MAX_RPM_RST, GAIN_RST, DECEL_RST, DEADZONE_RST);
                default: load_settings(12'($urandom_range(4095)), 8'($urandom_range(255)),
                                       12'($urandom_range(1) ? $urandom_range(64)
                                                            : $urandom_range(4095)),
                                       12'($urandom_range(600)));
            endcase

            // rotate the idle pattern
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 64; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 64; end
                default: begin idle_pct = 8; stall_pct = 8; end
            endcase

            for (int n = 0; n < PHASE_TICKS; n++) begin
                if (n == PHASE_TICKS / 2)
                    hold_until_drained();

                // mostly a steady request that flips now and then
                if ($urandom_range(99) < 6)
                    want_dir = ~want_dir;
                dir = want_dir;
                if ($urandom_range(99) < 3)
                    dir = ~dir;

                // encoder: often stopped, mostly small steps, rare jumps
                case ($urandom_range(9))
                    0, 1, 2: ;
                    3, 4, 5: enc_count = enc_count + COUNT_W'($urandom_range(40));
                    6, 7:    enc_count = enc_count + COUNT_W'($urandom_range(3000));
                    8:       enc_count = enc_count + COUNT_W'($urandom_range(300000));
                    default: enc_count = $urandom();
                endcase

                // knob: full range, near the dead zone edge, or at the ends
                case ($urandom_range(3))
                    1: begin
                        k = int'(cur_deadzone) + int'($urandom_range(4)) - 2;
                        if (k < 0) k = 0;
                        if (k > 4095) k = 4095;
                        knob = 12'(k);
                    end
                    2: knob = $urandom_range(1) ? 12'($urandom_range(4095, 4000))
                                                : 12'($urandom_range(20));
                    default: knob = 12'($urandom_range(4095));
                endcase

                send_tick(knob, dir, enc_count);
            end
            hold_until_drained();
        end

        hold_until_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("summary: %0d ticks (%0d directed) over %0d register settings,",
                 ticks_sent, DIRECTED_N, settings_used + 1);
        $display("summary: four idle patterns, reversal ramps and drain pauses each phase");
        if (errors == 0) begin
            $display("dc_motor_speed_loop_with_reversal_top_tb: done, clean");
        end else begin
            $display("dc_motor_speed_loop_with_reversal_top_tb: done, errors");
        end
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/dcmsl_pkg.sv
hw/rtl/dc_motor_speed_loop_with_reversal_top.sv
tb/sv/dc_motor_speed_loop_with_reversal_checker.sv
tb/sv/dc_motor_speed_loop_with_reversal_top_tb.sv
